// File: src/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the front end, the task queue, the back end and the top level.
package utf8d_pkg;

  localparam int CP_W     = 21;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // One decoded byte's worth of output: a run of replacement code points,
  // optionally followed by one final result.
  typedef struct packed {
    logic [1:0]      n_rep;
    logic            has_final;
    logic [CP_W-1:0] cp;
    logic            eot;
  } task_t;

endpackage

// File: src/utf8d_front.sv
// Front end: accepts text bytes, tracks the open sequence, emits tasks.
// Depends on utf8d_pkg.
module utf8d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  output logic                  push,
  output utf8d_pkg::task_t      push_task
);

  logic [utf8d_pkg::CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]                 bytes_expected, bytes_expected_next;
  logic [1:0]                 bytes_held, bytes_held_next;

  logic [utf8d_pkg::CP_W-1:0] shifted;

  always_comb begin
    shifted             = {partial_value[utf8d_pkg::CP_W-7:0], text_byte[5:0]};
    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    bytes_held_next     = bytes_held;
    push_task.n_rep     = 2'd0;
    push_task.has_final = 1'b0;
    push_task.cp        = '0;
    push_task.eot       = 1'b0;
    if (bytes_expected != 2'd0 && text_byte[7:6] == 2'b10) begin
      partial_value_next  = shifted;
      bytes_expected_next = bytes_expected - 2'd1;
      bytes_held_next     = bytes_held + 2'd1;
      if (bytes_expected == 2'd1) begin
        push_task.has_final = 1'b1;
        push_task.cp        = shifted;
        partial_value_next  = '0;
        bytes_held_next     = 2'd0;
      end
    end else begin
      if (bytes_expected != 2'd0) begin
        push_task.n_rep = (bytes_held > 2'd2) ? 2'd3 : bytes_held + 2'd1;
      end
      partial_value_next  = '0;
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      if (text_byte == 8'h00) begin
        push_task.has_final = 1'b1;
        push_task.eot       = 1'b1;
      end else if (text_byte inside {[8'h01:8'h7F]}) begin
        push_task.has_final = 1'b1;
        push_task.cp        = {{(utf8d_pkg::CP_W-8){1'b0}}, text_byte};
      end else if (text_byte inside {[8'hC0:8'hDF]}) begin
        partial_value_next  = {{(utf8d_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
        bytes_expected_next = 2'd1;
      end else if (text_byte inside {[8'hE0:8'hEF]}) begin
        partial_value_next  = {{(utf8d_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
        bytes_expected_next = 2'd2;
      end else if (text_byte inside {[8'hF0:8'hF7]}) begin
        partial_value_next  = {{(utf8d_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
        bytes_expected_next = 2'd3;
      end else begin
        push_task.has_final = 1'b1;
        push_task.cp        = utf8d_pkg::REPLACEMENT_CP;
      end
    end
  end

  assign push = accept && (push_task.has_final || push_task.n_rep != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= '0;
      bytes_expected <= 2'd0;
      bytes_held     <= 2'd0;
    end else if (accept) begin
      partial_value  <= partial_value_next;
      bytes_expected <= bytes_expected_next;
      bytes_held     <= bytes_held_next;
    end
  end

endmodule

// File: src/utf8d_queue.sv
// Short task queue between the front end and the back end.
// Depends on utf8d_pkg.
module utf8d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utf8d_pkg::task_t push_task,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output utf8d_pkg::task_t head
);

  utf8d_pkg::task_t                 mem [utf8d_pkg::QDEPTH];
  logic [utf8d_pkg::QPTR_W-1:0]     wr_ptr;
  logic [utf8d_pkg::QPTR_W-1:0]     rd_ptr;
  logic [utf8d_pkg::QCNT_W-1:0]     count;

  assign full     = (count == utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/utf8d_back.sv
// Back end: expands queued tasks into result transactions, one per cycle while m_tready does not stall it.
// Depends on utf8d_pkg.
module utf8d_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  utf8d_pkg::task_t           head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0] out_cp,
  output logic                       out_eot,
  output logic                       out_last
);

  logic [1:0]                 idx;
  logic [2:0]                 total;
  logic                       emit;
  logic                       is_rep;
  logic                       item_last;

  assign total     = {1'b0, head.n_rep} + {2'b00, head.has_final};
  assign is_rep    = (idx < head.n_rep);
  assign item_last = ({1'b0, idx} == total - 3'd1);
  assign emit      = head_valid && (!out_valid || out_ready);
  assign pop       = emit && item_last;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp   <= is_rep ? utf8d_pkg::REPLACEMENT_CP : head.cp;
      out_eot  <= is_rep ? 1'b0 : head.eot;
      out_last <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= item_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: front end, task queue, back end.
// A byte's task is queued, then its results are registered at the output.
// Throughput: one byte per cycle into the front end while the queue is not
// full; the back end emits a task's results, one per cycle when not stalled.
// Reset (rst, synchronous): closes any open sequence, empties the queue and
// drops any pending result.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tuser,   // [0] end_of_text
  output logic        m_tlast
);

  logic                       full;
  logic                       nonempty;
  logic                       push;
  logic                       pop;
  utf8d_pkg::task_t           push_task;
  utf8d_pkg::task_t           head;
  logic [utf8d_pkg::CP_W-1:0] out_cp;

  assign s_tready = !full;

  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .text_byte (s_tdata),
    .push      (push),
    .push_task (push_task)
  );

  utf8d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cp     (out_cp),
    .out_eot    (m_tuser),
    .out_last   (m_tlast)
  );

  assign m_tdata = {{(24-utf8d_pkg::CP_W){1'b0}}, out_cp};

endmodule
